@@ rtl/core/mts_pkg.sv @@
// mts_pkg: widths, codes and shared types for the min tracking stack
// no dependencies; used by the interfaces and by every rtl/core module except mts_ram

package mts_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int STACK_DEPTH = 256;
  localparam int WORD_WIDTH  = DATA_WIDTH + 2;
  localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
  localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic [ADDR_WIDTH-1:0]        addr_t;
  typedef logic [CNT_WIDTH-1:0]         cnt_t;

  typedef struct packed {
    status_t status;
    data_t   popped_value;
    data_t   top_value;
    data_t   min_value;
    cnt_t    depth_used;
    logic    is_empty;
  } result_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

endpackage

@@ rtl/core/mts_if.sv @@
// mts_in_if / mts_out_if: valid-ready channels for items and results
// depends on mts_pkg

interface mts_in_if;
  import mts_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  data_t value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface mts_out_if;
  import mts_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  data_t   popped_value;
  data_t   top_value;
  data_t   min_value;
  cnt_t    depth_used;
  logic    is_empty;

  modport source (output valid, output status, output popped_value, output top_value,
                  output min_value, output depth_used, output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input top_value,
                  input min_value, input depth_used, input is_empty, output ready);
endinterface

@@ rtl/core/mts_ram.sv @@
// mts_ram: generic one-write one-read ram, registered read, write-through
// no package dependency

module mts_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      // same-cycle write to the read address returns the new word
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

@@ rtl/core/mts_core.sv @@
// mts_core: stack state (count, minimum, cached top word) and the per-item update
// depends on mts_pkg; drives the entry ram through a ram_req_t

module mts_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             func,
  input  mts_pkg::data_t   value,
  input  mts_pkg::word_t   second_word,
  output mts_pkg::ram_req_t ram_req,
  output mts_pkg::result_t res
);
  import mts_pkg::*;

  cnt_t  sp_r, sp_nxt;
  data_t min_r, min_nxt;
  word_t top_r, top_nxt;

  word_t   val_w, min_w, enc_w, restore_w;
  logic    full, empty, val_lt_min, top_gt_min, new_top_gt_min;
  status_t status;
  data_t   popped;
  word_t   min_nxt_w;
  cnt_t    rd_idx;

  always_comb begin
    val_w      = word_t'(value);
    min_w      = word_t'(min_r);
    enc_w      = (val_w <<< 1) - min_w;
    restore_w  = (min_w <<< 1) - top_r;
    full       = (sp_r == cnt_t'(STACK_DEPTH));
    empty      = (sp_r == '0);
    val_lt_min = (value < min_r);
    top_gt_min = (top_r > min_w);

    sp_nxt  = sp_r;
    min_nxt = min_r;
    top_nxt = top_r;
    status  = ST_OK;
    popped  = '0;
    ram_req.we    = 1'b0;
    ram_req.waddr = addr_t'(sp_r - cnt_t'(1));
    ram_req.wdata = top_r;

    if (func == FUNC_PUSH) begin
      if (full) begin
        status = ST_OVERFLOW;
      end else begin
        sp_nxt = sp_r + cnt_t'(1);
        // old top moves down into the ram
        ram_req.we = fire && !empty;
        if (empty) begin
          top_nxt = val_w;
          min_nxt = value;
        end else if (val_lt_min) begin
          top_nxt = enc_w;
          min_nxt = value;
        end else begin
          top_nxt = val_w;
        end
      end
    end else begin
      if (empty) begin
        status = ST_UNDERFLOW;
      end else begin
        sp_nxt  = sp_r - cnt_t'(1);
        top_nxt = second_word;
        if (top_gt_min) begin
          popped = top_r[DATA_WIDTH-1:0];
        end else begin
          // encoded word: current minimum leaves, previous one comes back
          popped  = min_r;
          min_nxt = restore_w[DATA_WIDTH-1:0];
        end
      end
    end

    // fetch the entry that sits below the new top
    rd_idx        = sp_nxt - cnt_t'(2);
    ram_req.re    = fire;
    ram_req.raddr = rd_idx[ADDR_WIDTH-1:0];

    min_nxt_w      = word_t'(min_nxt);
    new_top_gt_min = (top_nxt > min_nxt_w);

    res.status       = status;
    res.popped_value = popped;
    res.depth_used   = sp_nxt;
    res.is_empty     = (sp_nxt == '0);
    if (sp_nxt == '0) begin
      res.top_value = '0;
      res.min_value = '0;
    end else begin
      res.top_value = new_top_gt_min ? top_nxt[DATA_WIDTH-1:0] : min_nxt;
      res.min_value = min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      min_r <= '0;
    end else if (fire) begin
      sp_r  <= sp_nxt;
      min_r <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      top_r <= top_nxt;
    end
  end

endmodule

@@ rtl/core/min_tracking_stack.sv @@
// min_tracking_stack: lifo of signed words that also reports the running minimum
// result path: an accepted item passes the input register and then the result register
//   before out_ch.valid rises; a stall on out_ch holds it in the input register
// throughput: one push or pop per cycle while out_ch takes results; the top word is held in
//   a register and the entry below it is prefetched from the ram with every item
// reset (rst_n low, synchronous): stack empty, minimum zero, both stages empty;
//   the entry ram is not cleared, a word read from it is only used after being written
// depends on mts_pkg, mts_if, mts_ram, mts_core

module min_tracking_stack (
  input  logic      clk,
  input  logic      rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);
  import mts_pkg::*;

  logic     stage_valid_r;
  logic     stage_func_r;
  data_t    stage_value_r;
  logic     out_valid_r;
  result_t  out_res_r;
  logic     fire;
  ram_req_t ram_req;
  word_t    second_word;
  result_t  res;

  assign fire        = stage_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stage_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        stage_valid_r <= in_ch.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_func_r  <= in_ch.func;
      stage_value_r <= in_ch.value;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  mts_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .func        (stage_func_r),
    .value       (stage_value_r),
    .second_word (second_word),
    .ram_req     (ram_req),
    .res         (res)
  );

  mts_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (second_word)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.popped_value = out_res_r.popped_value;
  assign out_ch.top_value    = out_res_r.top_value;
  assign out_ch.min_value    = out_res_r.min_value;
  assign out_ch.depth_used   = out_res_r.depth_used;
  assign out_ch.is_empty     = out_res_r.is_empty;

endmodule

@@ rtl/core/mts_checker.sv @@
// mts_checker: port-level checks on the min tracking stack results
// depends on mts_pkg; bound to min_tracking_stack below

module mts_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input logic [1:0]     status,
  input mts_pkg::data_t popped_value,
  input mts_pkg::data_t top_value,
  input mts_pkg::data_t min_value,
  input mts_pkg::cnt_t  depth_used,
  input logic           is_empty
);
  import mts_pkg::*;

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(depth_used))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (depth_used == '0)) && (depth_used <= cnt_t'(STACK_DEPTH)))
    else $error("empty flag and depth disagree");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> top_value == '0 && min_value == '0)
    else $error("empty stack reports nonzero top or minimum");

  // the minimum never exceeds the top entry
  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_empty |-> min_value <= top_value)
    else $error("minimum above top value");

  a_fail_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_UNDERFLOW || status == ST_OVERFLOW) |-> popped_value == '0)
    else $error("failed item reports a popped value");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .popped_value (out_ch.popped_value),
  .top_value    (out_ch.top_value),
  .min_value    (out_ch.min_value),
  .depth_used   (out_ch.depth_used),
  .is_empty     (out_ch.is_empty)
);

@@ dv/min_tracking_stack_tb.sv @@
// min_tracking_stack_tb: random and directed push/pop traffic with a scoreboard that
// tracks the stack contents and the encoded running minimum
// depends on mts_pkg, mts_if and the min_tracking_stack rtl
`timescale 1ns / 100ps

module min_tracking_stack_tb;
  import mts_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;
  localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

  class stack_scoreboard;
    word_t   entries [STACK_DEPTH];
    int      depth;
    data_t   cur_min;
    result_t expected_q [$];
    int      errors;

    function new();
      depth   = 0;
      cur_min = '0;
      errors  = 0;
    endfunction

    // advance the stack for one accepted item and queue the result it should give
    function void note_item(logic func, data_t value);
      result_t r;
      word_t   w;
      r = '0;
      r.status = ST_OK;
      if (func == FUNC_PUSH) begin
        if (depth >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          w = word_t'(value);
          if (depth == 0) begin
            cur_min = value;
          end else if (value < cur_min) begin
            // below the minimum: store 2*value - min, the old minimum is recovered on pop
            w = (word_t'(value) <<< 1) - word_t'(cur_min);
            cur_min = value;
          end
          entries[depth] = w;
          depth++;
        end
      end else begin
        if (depth == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          w = entries[depth-1];
          if (w > word_t'(cur_min)) begin
            r.popped_value = data_t'(w);
          end else begin
            r.popped_value = cur_min;
            cur_min = data_t'((word_t'(cur_min) <<< 1) - w);
          end
          depth--;
        end
      end
      if (depth > 0) begin
        w = entries[depth-1];
        r.top_value = (w > word_t'(cur_min)) ? data_t'(w) : cur_min;
        r.min_value = cur_min;
      end
      r.depth_used = cnt_t'(depth);
      r.is_empty   = (depth == 0);
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d popped=%0d top=%0d min=%0d depth=%0d",
                   $realtime, got.status, got.popped_value, got.top_value, got.min_value,
                   got.depth_used);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.popped_value !== exp.popped_value ||
          got.top_value !== exp.top_value || got.min_value !== exp.min_value ||
          got.depth_used !== exp.depth_used || got.is_empty !== exp.is_empty) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch exp status=%0d popped=%0d top=%0d min=%0d depth=%0d empty=%0b",
                   $realtime, exp.status, exp.popped_value, exp.top_value, exp.min_value,
                   exp.depth_used, exp.is_empty);
          $display("%0t:          got status=%0d popped=%0d top=%0d min=%0d depth=%0d empty=%0b",
                   $realtime, got.status, got.popped_value, got.top_value, got.min_value,
                   got.depth_used, got.is_empty);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int failures();
      return errors + expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   hold_left;
  bit   calm;

  stack_scoreboard sb;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  min_tracking_stack dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("min_tracking_stack test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mix of full-range, small (lots of ties), extremes and values hugging the minimum
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return data_t'($urandom);
      3, 4, 5: return data_t'($urandom_range(0, 16)) - 8;
      6: begin
        if ($urandom_range(0, 1)) return DATA_MAX - data_t'($urandom_range(0, 3));
        return DATA_MIN + data_t'($urandom_range(0, 3));
      end
      default: return sb.cur_min - data_t'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_item(input logic func, input data_t value);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(func, value);
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // push_weight out of 16: chance that a random item is a push
  task automatic run_random(input int count, input int push_weight, input int calm_items);
    for (int i = 0; i < count; i++) begin
      calm = (i < calm_items);
      if ($urandom_range(0, 15) < push_weight) send_item(FUNC_PUSH, pick_value());
      else send_item(FUNC_POP, data_t'($urandom));
    end
    calm = 1'b0;
  endtask

  // result side: checks every accepted result and stalls at random or while hold_left runs
  initial begin
    int      stall_left;
    result_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.status       = out_ch.status;
        got.popped_value = out_ch.popped_value;
        got.top_value    = out_ch.top_value;
        got.min_value    = out_ch.min_value;
        got.depth_used   = out_ch.depth_used;
        got.is_empty     = out_ch.is_empty;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    cycle_count = 0;
    hold_left   = 0;
    calm        = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= FUNC_PUSH;
    in_ch.value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, first push, plain pushes, ties, encoded pushes at the extremes, pops
    send_item(FUNC_POP, data_t'($urandom));
    send_item(FUNC_PUSH, 32'sd5);
    send_item(FUNC_PUSH, 32'sd7);
    send_item(FUNC_PUSH, 32'sd5);
    send_item(FUNC_PUSH, 32'sd3);
    send_item(FUNC_PUSH, DATA_MIN);
    send_item(FUNC_PUSH, DATA_MAX);
    send_item(FUNC_PUSH, DATA_MIN);
    repeat (7) send_item(FUNC_POP, data_t'($urandom));
    send_item(FUNC_POP, DATA_MAX);
    send_item(FUNC_PUSH, DATA_MAX);
    send_item(FUNC_PUSH, DATA_MIN);
    send_item(FUNC_POP, DATA_MIN);
    send_item(FUNC_POP, '0);
    send_item(FUNC_PUSH, -32'sd1);
    send_item(FUNC_PUSH, 32'sd0);
    send_item(FUNC_POP, -32'sd1);
    send_item(FUNC_POP, '0);
    wait_results();

    run_random(150, 9, 50);
    wait_results();

    // fill to full with a long result-side hold-off at the start, overflows at the top
    hold_left = 300;
    run_random(290, 15, 0);
    wait_results();

    // drain past empty for underflows
    run_random(300, 1, 0);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("min_tracking_stack test passed");
    end else begin
      $display("min_tracking_stack test failed");
    end
    $finish;
  end

endmodule

@@ min_tracking_stack.f @@
rtl/core/mts_pkg.sv
rtl/core/mts_if.sv
rtl/core/mts_ram.sv
rtl/core/mts_core.sv
rtl/core/min_tracking_stack.sv
rtl/core/mts_checker.sv
dv/min_tracking_stack_tb.sv
